@@ rtl/pcsma_pkg.sv @@
// shared types, constants and generator function for the csma gate
package pcsma_pkg;

    localparam int BLOCK_SIZE_DEFAULT = 128;
    localparam int CNT_W              = 16;
    localparam int SLOT_SCALE         = 240;
    localparam int CFG_IDX_W          = 2;
    localparam int CFG_DATA_W         = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_DUPLEX_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERSISTENCE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_UNITS  = 2'd2;

    localparam logic       DUPLEX_RESET      = 1'b0;
    localparam logic [7:0] PERSISTENCE_RESET = 8'd63;
    localparam logic [7:0] SLOT_UNITS_RESET  = 8'd10;

    typedef struct packed {
        logic carrier_detect;
        logic block_done;
    } item_t;

    typedef struct packed {
        logic       can_transmit;
        logic       slot_expired;
        logic [7:0] random_byte;
    } result_t;

    typedef struct packed {
        logic       duplex_mode;
        logic [7:0] persistence;
        logic [7:0] slot_units;
    } cfg_t;

    typedef struct packed {
        logic [7:0] x;
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] c;
    } rng_state_t;

    localparam rng_state_t RNG_SEED = '{x: 8'h01, a: 8'hB7, b: 8'h73, c: 8'hF6};

    // one mix pass: a ^= c ^ x, b += a, c = (c + (b >> 1)) ^ a
    function automatic rng_state_t rng_mix(input rng_state_t s);
        rng_state_t r;
        r   = s;
        r.a = s.a ^ s.c ^ s.x;
        r.b = s.b + r.a;
        r.c = (s.c + {1'b0, r.b[7:1]}) ^ r.a;
        return r;
    endfunction

    // seeds after the seeding mix
    localparam rng_state_t RNG_RESET = rng_mix(RNG_SEED);

endpackage

@@ rtl/pcsma_rng.sv @@
// 8-bit xabc pseudo-random generator, steps on request
module pcsma_rng (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    output logic [7:0] c_now
);

    pcsma_pkg::rng_state_t state_reg;
    pcsma_pkg::rng_state_t state_next;
    pcsma_pkg::rng_state_t stepped;

    always_comb
    begin
        stepped   = state_reg;
        stepped.x = state_reg.x + 8'd1;
        stepped   = pcsma_pkg::rng_mix(stepped);
        state_next = step ? stepped : state_reg;
    end

    assign c_now = state_next.c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pcsma_pkg::RNG_RESET;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/pcsma_slot.sv @@
// slot counter, transmit flag and result forming
module pcsma_slot #(
    parameter int BLOCK_SIZE = pcsma_pkg::BLOCK_SIZE_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  pcsma_pkg::item_t    item,
    input  pcsma_pkg::cfg_t     cfg,
    input  logic [7:0]          rng_c,
    output logic                rng_step,
    output pcsma_pkg::result_t  result
);

    localparam logic [pcsma_pkg::CNT_W-1:0] BLOCK_INC = pcsma_pkg::CNT_W'(BLOCK_SIZE);
    localparam logic [pcsma_pkg::CNT_W-1:0] SCALE = pcsma_pkg::CNT_W'(pcsma_pkg::SLOT_SCALE);

    logic [pcsma_pkg::CNT_W-1:0] counter_reg;
    logic [pcsma_pkg::CNT_W-1:0] counter_next;
    logic                        flag_reg;
    logic                        flag_next;
    logic [pcsma_pkg::CNT_W-1:0] slot_len;
    logic [pcsma_pkg::CNT_W-1:0] counter_inc;
    logic                        expire;

    assign slot_len    = pcsma_pkg::CNT_W'(cfg.slot_units) * SCALE;
    assign counter_inc = counter_reg + BLOCK_INC;

    always_comb
    begin
        counter_next = counter_reg;
        flag_next    = flag_reg;
        expire       = 1'b0;
        if (item.block_done && !cfg.duplex_mode)
        begin
            if (item.carrier_detect)
            begin
                counter_next = '0;
            end
            else if (counter_inc >= slot_len)
            begin
                counter_next = '0;
                expire       = 1'b1;
                flag_next    = (cfg.persistence >= rng_c);
            end
            else
            begin
                counter_next = counter_inc;
            end
        end
    end

    assign rng_step = fire && expire;

    always_comb
    begin
        result.slot_expired = expire;
        result.random_byte  = rng_c;
        if (cfg.duplex_mode)
            result.can_transmit = 1'b1;
        else if (item.carrier_detect)
            result.can_transmit = 1'b0;
        else
            result.can_transmit = flag_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_reg <= '0;
            flag_reg    <= 1'b0;
        end
        else if (fire)
        begin
            counter_reg <= counter_next;
            flag_reg    <= flag_next;
        end
    end

endmodule

@@ rtl/p_persistent_csma_gate.sv @@
// top level of the p-persistent csma channel-access gate
//
//  channel   signals                                  dir   moves
//  item      item_valid, item_stall, item             in    carrier level and block flag
//  result    result_valid, result_stall, result       out   transmit permit and draw
//  cfg       cfg_valid, cfg_ready, cfg_index, cfg_data in   register write
//
// an item is taken into the input register, and its result then passes into
// the result register; one item per cycle sustained while result_stall is low
// the step itself is one pass of counter add/compare and the xabc generator
// reset puts the generator at its seeded value and clears counter and flag
// a stalled result holds the result register; the input register then holds
// its item and item_stall rises until the result is taken
module p_persistent_csma_gate #(
    parameter int BLOCK_SIZE = pcsma_pkg::BLOCK_SIZE_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  pcsma_pkg::item_t                    item,
    output logic                                result_valid,
    input  logic                                result_stall,
    output pcsma_pkg::result_t                  result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pcsma_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pcsma_pkg::CFG_DATA_W-1:0]    cfg_data
);

    // configuration registers
    pcsma_pkg::cfg_t    cfg_reg;

    // input stage
    pcsma_pkg::item_t   item_reg;
    logic               item_valid_reg;

    // result stage
    pcsma_pkg::result_t result_reg;
    logic               result_valid_reg;

    logic               fire;
    logic               take;
    logic               rng_step;
    logic [7:0]         rng_c;
    pcsma_pkg::result_t step_result;

    // the input register moves on when the result slot is empty or draining
    assign fire       = item_valid_reg && (!result_valid_reg || !result_stall);
    assign item_stall = item_valid_reg && !fire;
    assign take       = item_valid && !item_stall;
    assign cfg_ready  = 1'b1;

    // config writes; an index past the list is ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.duplex_mode <= pcsma_pkg::DUPLEX_RESET;
            cfg_reg.persistence <= pcsma_pkg::PERSISTENCE_RESET;
            cfg_reg.slot_units  <= pcsma_pkg::SLOT_UNITS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                pcsma_pkg::CFG_DUPLEX_MODE: cfg_reg.duplex_mode <= cfg_data[0];
                pcsma_pkg::CFG_PERSISTENCE: cfg_reg.persistence <= cfg_data;
                pcsma_pkg::CFG_SLOT_UNITS:  cfg_reg.slot_units  <= cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            item_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            item_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= item;
        end
    end

    pcsma_rng u_rng (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (rng_step),
        .c_now (rng_c)
    );

    pcsma_slot #(
        .BLOCK_SIZE (BLOCK_SIZE)
    ) u_slot (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (fire),
        .item     (item_reg),
        .cfg      (cfg_reg),
        .rng_c    (rng_c),
        .rng_step (rng_step),
        .result   (step_result)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            result_reg <= step_result;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
